// ===== sv/udg_pkg.sv =====
// Shared widths, register indexes and reset values of the utilization DVFS governor.
package udg_pkg;

	localparam int FREQ_W      = 22;
	localparam int UTIL_W      = 17;
	localparam int CNT_IN_W    = 32;
	localparam int FRAC_BITS   = 16;
	localparam int QUO_BITS    = 22;
	localparam int STEP_CNT_W  = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int TDATA_IN_W  = 344;
	localparam int TDATA_OUT_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_FREQ  = 2'd0,
		REG_MAX_FREQ  = 2'd1,
		REG_FREQ_STEP = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = 22'd600000;
	localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = 22'd1800000;
	localparam logic [FREQ_W-1:0] FREQ_STEP_RST = 22'd100000;
	localparam logic [FREQ_W-1:0] FREQ_SAT      = 22'h3FFFFF;
	localparam logic [UTIL_W-1:0] UTIL_ONE      = 17'h10000;

endpackage

// ===== sv/utilization_dvfs_governor_core.sv =====
// Utilization based DVFS governor: per-sample busy ratios, peak core load and frequency pick.
//
//  channel   | direction | handshake                        | payload
//  ----------+-----------+----------------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready    | tick counters, present_freq
//  m_axis    | out       | m_axis_tvalid / m_axis_tready    | new_freq, peak_util
//  cfg       | in        | cfg_we (no wait, no read-back)   | cfg_index, cfg_data
//
// After its accepting beat, a sample passes the row states (busy, total delta, busy delta) for
// every row, a multiply, multiply and compare for every core after the first, and the same for
// the test on the aggregate ratio; a sample that changes it then runs the frequency pick, with
// the 22-step quotient for the frequency step count and the 16-step quotient for peak_util, all
// on the one shared multiplier and adder-subtractor. The next beat is taken back in idle.
// s_axis_tready is high only while the sequencer is idle. A finished result sits in the output
// register until taken, and the next sample is already accepted meanwhile; only a second result
// that is ready before the first was taken waits in the emit state.
// Reset clears the configuration to its defaults and the previous counters and ratio to zero.
module utilization_dvfs_governor_core
	import udg_pkg::*;
#(
	parameter int CORE_COUNT   = 4,
	parameter int COUNTER_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// s_axis_tdata, lowest bit up: all_total, all_idle, core0_total, core0_idle, core1_total,
	// core1_idle, core2_total, core2_idle, core3_total, core3_idle (32 bits each),
	// present_freq (22 bits), two zero bits.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
	// m_axis_tdata, lowest bit up: new_freq (22 bits), peak_util (17 bits), one zero bit.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [FREQ_W-1:0]      cfg_data
);

	// Counters wider than the 32-bit input fields carry no extra information.
	localparam int CW = (COUNTER_BITS < CNT_IN_W) ? COUNTER_BITS : CNT_IN_W;
	localparam int NR = CORE_COUNT + 1;
	localparam int RW = $clog2(NR);
	// Multiplier operands must hold a counter delta or the 23-bit step count.
	localparam int MW = (CW > QUO_BITS + 1) ? CW : QUO_BITS + 1;
	localparam int PW = 2 * MW;
	// The adder-subtractor holds a product times four plus headroom for five times a product.
	localparam int WW = PW + 2;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ROW_BUSY,
		S_ROW_DT,
		S_ROW_DB,
		S_PK_M1,
		S_PK_M2,
		S_PK_CMP,
		S_CH_M1,
		S_CH_M2,
		S_CH_CMP,
		S_DS_M,
		S_DS_NUM,
		S_DS_MAX,
		S_DS_MIN,
		S_DS_X1,
		S_DS_X2,
		S_DIV,
		S_DS_K,
		S_DS_KM,
		S_DS_RES,
		S_PQ_CHK,
		S_PQ_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	// Configuration.
	logic [FREQ_W-1:0] min_freq_q, max_freq_q, freq_step_q;
	logic [FREQ_W-1:0] step_eff;

	// Captured sample.
	logic [CW-1:0]     tot_q [NR];
	logic [CW-1:0]     idl_q [NR];
	logic [FREQ_W-1:0] cur_q;

	// History kept across samples.
	logic [CW-1:0] prev_total_q [NR];
	logic [CW-1:0] prev_busy_q  [NR];
	logic [CW-1:0] prev_all_n_q, prev_all_d_q;

	// Working registers.
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         busy_q, d_q;
	logic                  dpos_q;
	logic [CW-1:0]         rn_q [NR];
	logic [CW-1:0]         rd_q [NR];
	logic [CW-1:0]         peak_n_q, peak_d_q;
	logic [PW-1:0]         prod_q, p1_q;
	logic [WW-1:0]         num_q, rem_q;
	logic [QUO_BITS-1:0]   quo_q;
	logic [QUO_BITS:0]     kmag_q;
	logic                  xneg_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [FREQ_W-1:0]     freq_q;
	logic [UTIL_W-1:0]     pq_q;

	// Output register.
	logic                  m_valid_q;
	logic [FREQ_W-1:0]     m_freq_q;
	logic [UTIL_W-1:0]     m_peak_q;

	// Shared multiplier and adder-subtractor.
	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] mul_p;
	logic          mul_en;
	logic [WW-1:0] alu_a, alu_b, alu_diff;
	logic          alu_sub;
	logic [WW:0]   alu_sum;
	logic          alu_borrow, alu_zero;

	// Helpers.
	logic [CW-1:0] pv_n, pv_d;
	logic          rpos;
	logic [CW-1:0] rown_w, rowd_w;
	logic [WW-1:0] prod4, p14, div_t, pq_t;
	logic          last_row;
	logic          emit_go;

	assign step_eff = (freq_step_q == '0) ? FREQ_W'(1) : freq_step_q;

	// A zero denominator is what reset leaves and reads as a ratio of zero.
	assign pv_n = (prev_all_d_q == '0) ? '0 : prev_all_n_q;
	assign pv_d = (prev_all_d_q == '0) ? CW'(1) : prev_all_d_q;

	assign prod4    = {prod_q, 2'b00};
	assign p14      = {p1_q, 2'b00};
	assign div_t    = {rem_q[WW-2:0], quo_q[QUO_BITS-1]};
	assign pq_t     = {rem_q[WW-2:0], 1'b0};
	assign last_row = (row_q == RW'(CORE_COUNT));

	// The finished result moves to the output register once that register is free or drains.
	assign emit_go = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);

	assign mul_p = mul_a * mul_b;

	assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
	                  + {{WW{1'b0}}, alu_sub};
	assign alu_diff   = alu_sum[WW-1:0];
	assign alu_borrow = alu_sub & ~alu_sum[WW];
	assign alu_zero   = (alu_diff == '0);

	// A row has a ratio only when both its total and its busy delta are positive.
	assign rpos   = dpos_q & ~alu_borrow & ~alu_zero;
	assign rown_w = rpos ? alu_diff[CW-1:0] : '0;
	assign rowd_w = rpos ? d_q : CW'(1);

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_en  = 1'b0;
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			S_ROW_BUSY: begin
				alu_a = WW'(tot_q[row_q]);
				alu_b = WW'(idl_q[row_q]);
			end
			S_ROW_DT: begin
				alu_a = WW'(tot_q[row_q]);
				alu_b = WW'(prev_total_q[row_q]);
			end
			S_ROW_DB: begin
				alu_a = WW'(busy_q);
				alu_b = WW'(prev_busy_q[row_q]);
			end
			S_PK_M1: begin
				mul_a  = MW'(rn_q[row_q]);
				mul_b  = MW'(peak_d_q);
				mul_en = 1'b1;
			end
			S_PK_M2: begin
				mul_a  = MW'(peak_n_q);
				mul_b  = MW'(rd_q[row_q]);
				mul_en = 1'b1;
			end
			S_PK_CMP: begin
				alu_a = WW'(prod_q);
				alu_b = WW'(p1_q);
			end
			S_CH_M1: begin
				mul_a  = MW'(rn_q[0]);
				mul_b  = MW'(pv_d);
				mul_en = 1'b1;
			end
			S_CH_M2: begin
				mul_a  = MW'(pv_n);
				mul_b  = MW'(rd_q[0]);
				mul_en = 1'b1;
			end
			S_CH_CMP: begin
				alu_a = WW'(p1_q);
				alu_b = WW'(prod_q);
			end
			S_DS_M: begin
				mul_a  = MW'(max_freq_q);
				mul_b  = MW'(peak_n_q);
				mul_en = 1'b1;
			end
			S_DS_NUM: begin
				// Five times the product: four times plus once.
				alu_a   = prod4;
				alu_b   = WW'(prod_q);
				alu_sub = 1'b0;
				mul_a   = MW'(max_freq_q);
				mul_b   = MW'(peak_d_q);
				mul_en  = 1'b1;
			end
			S_DS_MAX: begin
				alu_a  = prod4;
				alu_b  = num_q;
				mul_a  = MW'(min_freq_q);
				mul_b  = MW'(peak_d_q);
				mul_en = 1'b1;
			end
			S_DS_MIN: begin
				alu_a  = num_q;
				alu_b  = prod4;
				mul_a  = MW'(cur_q);
				mul_b  = MW'(peak_d_q);
				mul_en = 1'b1;
			end
			S_DS_X1: begin
				alu_a  = num_q;
				alu_b  = prod4;
				mul_a  = MW'(step_eff);
				mul_b  = MW'(peak_d_q);
				mul_en = 1'b1;
			end
			S_DS_X2: begin
				alu_a = xneg_q ? p14 : num_q;
				alu_b = xneg_q ? num_q : p14;
			end
			S_DIV: begin
				alu_a = div_t;
				alu_b = prod4;
			end
			S_DS_K: begin
				alu_a   = WW'(quo_q);
				alu_b   = WW'(~xneg_q && (rem_q != '0));
				alu_sub = 1'b0;
			end
			S_DS_KM: begin
				mul_a  = MW'(kmag_q);
				mul_b  = MW'(step_eff);
				mul_en = 1'b1;
			end
			S_DS_RES: begin
				alu_a   = WW'(cur_q);
				alu_b   = WW'(prod_q);
				alu_sub = xneg_q;
			end
			S_PQ_CHK: begin
				alu_a = WW'(peak_n_q);
				alu_b = WW'(peak_d_q);
			end
			S_PQ_DIV: begin
				alu_a = pq_t;
				alu_b = WW'(peak_d_q);
			end
			default: begin
				alu_sub = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			min_freq_q   <= MIN_FREQ_RST;
			max_freq_q   <= MAX_FREQ_RST;
			freq_step_q  <= FREQ_STEP_RST;
			prev_all_n_q <= '0;
			prev_all_d_q <= '0;
			for (int r = 0; r < NR; r++) begin
				prev_total_q[r] <= '0;
				prev_busy_q[r]  <= '0;
			end
			row_q        <= '0;
			cnt_q        <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_MIN_FREQ:  min_freq_q  <= cfg_data;
					REG_MAX_FREQ:  max_freq_q  <= cfg_data;
					REG_FREQ_STEP: freq_step_q <= cfg_data;
					default:       ;
				endcase
			end

			if (mul_en) begin
				prod_q <= mul_p;
			end

			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						for (int r = 0; r < NR; r++) begin
							tot_q[r] <= s_axis_tdata[2*CNT_IN_W*r +: CW];
							idl_q[r] <= s_axis_tdata[2*CNT_IN_W*r + CNT_IN_W +: CW];
						end
						cur_q   <= s_axis_tdata[10*CNT_IN_W +: FREQ_W];
						row_q   <= '0;
						state_q <= S_ROW_BUSY;
					end
				end
				S_ROW_BUSY: begin
					// Idle above total counts as no busy ticks.
					busy_q  <= alu_borrow ? '0 : alu_diff[CW-1:0];
					state_q <= S_ROW_DT;
				end
				S_ROW_DT: begin
					d_q     <= alu_diff[CW-1:0];
					dpos_q  <= ~alu_borrow & ~alu_zero;
					state_q <= S_ROW_DB;
				end
				S_ROW_DB: begin
					rn_q[row_q]         <= rown_w;
					rd_q[row_q]         <= rowd_w;
					prev_total_q[row_q] <= tot_q[row_q];
					prev_busy_q[row_q]  <= busy_q;
					if (row_q == RW'(1)) begin
						peak_n_q <= rown_w;
						peak_d_q <= rowd_w;
					end
					if (!last_row) begin
						row_q   <= RW'(row_q + 1'b1);
						state_q <= S_ROW_BUSY;
					end else if (CORE_COUNT >= 2) begin
						row_q   <= RW'(2);
						state_q <= S_PK_M1;
					end else begin
						state_q <= S_CH_M1;
					end
				end
				S_PK_M1: begin
					state_q <= S_PK_M2;
				end
				S_PK_M2: begin
					p1_q    <= prod_q;
					state_q <= S_PK_CMP;
				end
				S_PK_CMP: begin
					// The candidate wins only when strictly above the running peak.
					if (alu_borrow) begin
						peak_n_q <= rn_q[row_q];
						peak_d_q <= rd_q[row_q];
					end
					if (last_row) begin
						state_q <= S_CH_M1;
					end else begin
						row_q   <= RW'(row_q + 1'b1);
						state_q <= S_PK_M1;
					end
				end
				S_CH_M1: begin
					state_q <= S_CH_M2;
				end
				S_CH_M2: begin
					p1_q    <= prod_q;
					state_q <= S_CH_CMP;
				end
				S_CH_CMP: begin
					prev_all_n_q <= rn_q[0];
					prev_all_d_q <= rd_q[0];
					state_q      <= alu_zero ? S_IDLE : S_DS_M;
				end
				S_DS_M: begin
					state_q <= S_DS_NUM;
				end
				S_DS_NUM: begin
					num_q   <= alu_diff;
					state_q <= S_DS_MAX;
				end
				S_DS_MAX: begin
					if (alu_borrow) begin
						freq_q  <= max_freq_q;
						state_q <= S_PQ_CHK;
					end else begin
						state_q <= S_DS_MIN;
					end
				end
				S_DS_MIN: begin
					if (alu_borrow) begin
						freq_q  <= min_freq_q;
						state_q <= S_PQ_CHK;
					end else begin
						state_q <= S_DS_X1;
					end
				end
				S_DS_X1: begin
					xneg_q  <= alu_borrow;
					p1_q    <= prod_q;
					state_q <= S_DS_X2;
				end
				S_DS_X2: begin
					// The distance is below the divisor shifted by the quotient width,
					// so its top part already lies below the divisor.
					rem_q   <= alu_diff >> QUO_BITS;
					quo_q   <= alu_diff[QUO_BITS-1:0];
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= alu_borrow ? div_t : alu_diff;
					quo_q <= {quo_q[QUO_BITS-2:0], ~alu_borrow};
					cnt_q <= STEP_CNT_W'(cnt_q + 1'b1);
					if (cnt_q == STEP_CNT_W'(QUO_BITS - 1)) begin
						state_q <= S_DS_K;
					end
				end
				S_DS_K: begin
					// Upward moves round the step count up, downward moves toward zero.
					kmag_q  <= alu_diff[QUO_BITS:0];
					state_q <= S_DS_KM;
				end
				S_DS_KM: begin
					state_q <= S_DS_RES;
				end
				S_DS_RES: begin
					freq_q  <= (alu_diff[WW-1:FREQ_W] != '0) ? FREQ_SAT : alu_diff[FREQ_W-1:0];
					state_q <= S_PQ_CHK;
				end
				S_PQ_CHK: begin
					if (!alu_borrow) begin
						pq_q    <= UTIL_ONE;
						state_q <= S_EMIT;
					end else begin
						rem_q   <= WW'(peak_n_q);
						pq_q    <= '0;
						cnt_q   <= '0;
						state_q <= S_PQ_DIV;
					end
				end
				S_PQ_DIV: begin
					rem_q <= alu_borrow ? pq_t : alu_diff;
					pq_q  <= {1'b0, pq_q[FRAC_BITS-2:0], ~alu_borrow};
					cnt_q <= STEP_CNT_W'(cnt_q + 1'b1);
					if (cnt_q == STEP_CNT_W'(FRAC_BITS - 1)) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						m_freq_q <= freq_q;
						m_peak_q <= pq_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = TDATA_OUT_W'({m_peak_q, m_freq_q});

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("sample accepted while previous sample still in work");

	a_step_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < prod4))
		else $error("step-count remainder not below divisor");

	a_step_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q < STEP_CNT_W'(QUO_BITS)))
		else $error("step-count division overran");

	a_util_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PQ_DIV) |-> (rem_q < WW'(peak_d_q)))
		else $error("utilization remainder not below denominator");

	a_util_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_peak_q <= UTIL_ONE))
		else $error("peak utilization above full scale");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the utilization DVFS governor core.
module tb;
	import udg_pkg::*;

	// One beat on the sample stream carries five rows of cumulative tick counters:
	// row 0 is the aggregate, rows 1 to 4 are the cores. Each row holds a total and an idle count.
	localparam int ROWS          = 5;
	localparam int SETTLE_CYCLES = 100;
	localparam int TAIL_CYCLES   = 100;
	localparam int WATCH_LIMIT   = 4000;  // cycles with no beat on either stream
	localparam int DIR_ROWS      = 17;

	// How a directed row gets its expectation: from the predictor, none at all, or typed in.
	typedef enum logic [1:0] {
		EXP_PREDICTED,
		EXP_NONE,
		EXP_GIVEN
	} exp_kind_t;

	typedef struct packed {
		logic [ROWS-1:0][31:0] tot;
		logic [ROWS-1:0][31:0] idl;
		logic [FREQ_W-1:0]     khz;
	} sample_t;

	typedef struct packed {
		logic [FREQ_W-1:0] khz;
		logic [UTIL_W-1:0] util;
	} pick_t;

	typedef struct packed {
		logic [31:0]       agg_tot, agg_idl, c0_tot, c0_idl, c1_tot, c1_idl;
		logic [31:0]       c2_tot, c2_idl, c3_tot, c3_idl;
		logic [FREQ_W-1:0] khz;
		exp_kind_t         kind;
		logic [FREQ_W-1:0] want_khz;
		logic [UTIL_W-1:0] want_util;
	} dir_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// Fields from the lowest bit up: all_total, all_idle, core0..3 total and idle (32 bits each),
	// present_freq (22 bits), two zero bits.
	logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// Fields from the lowest bit up: new_freq (22 bits), peak_util (17 bits), one zero bit.
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   cfg_we        = 1'b0;
	reg_idx_t               cfg_index     = REG_MIN_FREQ;
	logic [FREQ_W-1:0]      cfg_data      = '0;

	// Predictor state: the previous counters and the previous aggregate ratio, plus a mirror of
	// the three frequency registers.
	logic [31:0]       seen_tot  [ROWS] = '{default: '0};
	logic [31:0]       seen_busy [ROWS] = '{default: '0};
	logic [63:0]       agg_num          = '0;
	logic [63:0]       agg_den          = '0;
	logic [FREQ_W-1:0] floor_khz        = MIN_FREQ_RST;
	logic [FREQ_W-1:0] ceil_khz         = MAX_FREQ_RST;
	logic [FREQ_W-1:0] step_khz         = FREQ_STEP_RST;

	// Running counters for the random part, so that most samples form a plausible sequence.
	logic [31:0] run_tot [ROWS] = '{default: '0};
	logic [31:0] run_idl [ROWS] = '{default: '0};
	logic [31:0] last_dt [ROWS] = '{default: '0};
	logic [31:0] last_di [ROWS] = '{default: '0};

	pick_t    pending_picks [$];
	dir_row_t dir_tab [DIR_ROWS];

	bit src_gaps  = 1'b0;
	bit sink_gaps = 1'b0;
	int mismatches    = 0;
	int samples_sent  = 0;
	int picks_checked = 0;
	int settings_used = 1;
	int quiet_cycles  = 0;

	utilization_dvfs_governor_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Works out the frequency pick for one sample and advances the predictor state. Ratios stay
	// exact as numerator and denominator; every comparison is a cross-multiplication.
	function automatic void predict_pick(input sample_t smp, output bit emits,
			output pick_t pick);
		logic [63:0] rn [ROWS];
		logic [63:0] rd [ROWS];
		logic [63:0] pn, pd, qn, qd, num, den, stp, quo;
		logic [31:0] busy;
		longint      dt, db, x, y, k, res;
		for (int r = 0; r < ROWS; r++) begin
			// An idle count above the total means the row is taken as not busy at all.
			busy = (smp.tot[r] >= smp.idl[r]) ? smp.tot[r] - smp.idl[r] : 32'd0;
			dt = longint'({32'd0, smp.tot[r]}) - longint'({32'd0, seen_tot[r]});
			db = longint'({32'd0, busy}) - longint'({32'd0, seen_busy[r]});
			rn[r] = 64'd0;
			rd[r] = 64'd1;
			// A wrapped or stalled total, or a falling busy count, gives a zero ratio.
			if (dt > 0 && db > 0) begin
				rn[r] = 64'(db);
				rd[r] = 64'(dt);
			end
			seen_tot[r]  = smp.tot[r];
			seen_busy[r] = busy;
		end
		// Peak over the cores only; on a tie the lower core is kept.
		pn = rn[1];
		pd = rd[1];
		for (int r = 2; r < ROWS; r++) begin
			if (rn[r] * pd > pn * rd[r]) begin
				pn = rn[r];
				pd = rd[r];
			end
		end
		// A zero denominator, as after reset, reads as a zero ratio.
		qn = agg_num;
		qd = agg_den;
		if (qd == 64'd0) begin
			qn = 64'd0;
			qd = 64'd1;
		end
		emits   = (rn[0] * qd != qn * rd[0]);
		agg_num = rn[0];
		agg_den = rd[0];
		pick    = '0;
		if (emits) begin
			// desired = 1.25 * max * peak, kept as num / den.
			num = 64'd5 * ceil_khz * pn;
			den = 64'd4 * pd;
			if (num > ceil_khz * den) begin
				pick.khz = ceil_khz;
			end else if (num < floor_khz * den) begin
				pick.khz = floor_khz;
			end else begin
				// Whole steps from the present frequency: up to at least the desired one, down without passing it.
				stp = (step_khz == '0) ? 64'd1 : 64'(step_khz);
				x   = longint'(num) - longint'(smp.khz * den);
				y   = longint'(stp * den);
				k   = (x >= 0) ? (x + y - 1) / y : -((-x) / y);
				res = longint'({42'd0, smp.khz}) + k * longint'(stp);
				if (res < 0) begin
					res = 0;
				end
				pick.khz = (res > longint'({42'd0, FREQ_SAT})) ? FREQ_SAT : res[FREQ_W-1:0];
			end
			quo       = (pn << 16) / pd;
			pick.util = (quo > 64'd65536) ? UTIL_ONE : quo[UTIL_W-1:0];
		end
	endfunction

	// Presents one sample beat, waits for it to be taken, then queues what it should produce.
	// Valid is only lowered when a gap is wanted, so it is never dropped and raised in one step.
	task automatic feed_sample(input sample_t smp, input exp_kind_t kind, input pick_t given);
		logic [TDATA_IN_W-1:0] beat;
		pick_t                 pick;
		bit                    emits;
		beat = '0;
		for (int r = 0; r < ROWS; r++) begin
			beat[64*r +: 32]      = smp.tot[r];
			beat[64*r + 32 +: 32] = smp.idl[r];
			run_tot[r]            = smp.tot[r];
			run_idl[r]            = smp.idl[r];
		end
		beat[64*ROWS +: FREQ_W] = smp.khz;
		if (src_gaps && $urandom_range(0, 99) < 18) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 18);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		predict_pick(smp, emits, pick);
		case (kind)
			EXP_PREDICTED: begin
				if (emits) begin
					pending_picks.push_back(pick);
				end
			end
			EXP_GIVEN: pending_picks.push_back(given);
			default: ;
		endcase
	endtask

	// Stops feeding and waits for every pick to come back. A sample whose aggregate ratio did not
	// change may still be in flight, so SETTLE_CYCLES more pass and tready must be seen again.
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_picks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [FREQ_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_MIN_FREQ:  floor_khz = val;
			REG_MAX_FREQ:  ceil_khz  = val;
			REG_FREQ_STEP: step_khz  = val;
			default: ;
		endcase
	endtask

	// Loads floor, ceiling and step back to back; optionally pokes the spare index, which the
	// block must ignore.
	task automatic load_limits(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi,
			input logic [FREQ_W-1:0] stp, input bit poke_spare);
		write_reg(REG_MIN_FREQ, lo);
		write_reg(REG_MAX_FREQ, hi);
		write_reg(REG_FREQ_STEP, stp);
		if (poke_spare) begin
			write_reg(REG_UNUSED, FREQ_W'($urandom_range(0, FREQ_SAT)));
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Random samples. Most advance every row by a plausible number of ticks; some repeat the
	// last ratios scaled up (no pick expected), some let idle run backward or past the total,
	// and a few are pure noise that also wraps the counters.
	task automatic run_random(input int count, input bit force_pause);
		sample_t     smp;
		int          mode;
		int          mult;
		logic [31:0] dt, di;
		for (int n = 0; n < count; n++) begin
			if ((force_pause && n == count / 2) || $urandom_range(0, 149) == 0) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_picks.size() != 0) @(posedge clk);
			end
			mode = $urandom_range(0, 99);
			mult = $urandom_range(1, 3);
			for (int r = 0; r < ROWS; r++) begin
				if (mode >= 90) begin
					smp.tot[r] = $urandom;
					smp.idl[r] = $urandom;
				end else begin
					if (mode < 70) begin
						dt = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 4000);
						di = $urandom_range(0, dt);
						last_dt[r] = dt;
						last_di[r] = di;
					end else if (mode < 80) begin
						dt = last_dt[r] * mult;
						di = last_di[r] * mult;
					end else begin
						dt = $urandom_range(0, 4000);
						di = $urandom_range(0, 8000) - 32'd4000;
					end
					smp.tot[r] = run_tot[r] + dt;
					smp.idl[r] = run_idl[r] + di;
				end
			end
			case ($urandom_range(0, 9))
				0:       smp.khz = '0;
				1:       smp.khz = FREQ_SAT;
				2, 3, 4, 5: smp.khz = FREQ_W'($urandom_range(0, FREQ_SAT));
				default: smp.khz = (ceil_khz > 22'h1FFFFF) ? FREQ_W'($urandom_range(0, FREQ_SAT))
						: FREQ_W'($urandom_range(0, 2 * int'(ceil_khz)));
			endcase
			feed_sample(smp, EXP_PREDICTED, '0);
		end
	endtask

	// The receiver stalls at random when asked to, and is always ready otherwise.
	always @(posedge clk) begin
		m_axis_tready <= !(sink_gaps && $urandom_range(0, 99) < 18);
	end

	// Every pick leaving the block is matched field by field against the oldest expectation.
	always @(posedge clk) begin : pick_monitor
		pick_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			picks_checked++;
			if (pending_picks.size() == 0) begin
				note_mismatch($sformatf("pick with nothing expected, tdata %h", m_axis_tdata));
			end else begin
				want = pending_picks.pop_front();
				if (m_axis_tdata[FREQ_W-1:0] !== want.khz) begin
					note_mismatch($sformatf("new_freq %0d, expected %0d",
						m_axis_tdata[FREQ_W-1:0], want.khz));
				end
				if (m_axis_tdata[FREQ_W +: UTIL_W] !== want.util) begin
					note_mismatch($sformatf("peak_util %0d, expected %0d",
						m_axis_tdata[FREQ_W +: UTIL_W], want.util));
				end
			end
		end
	end

	// A run that stops moving on both streams for too long has hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("timeout with %0d picks outstanding", pending_picks.size());
			$display("utilization_dvfs_governor_core verification failed");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		sample_t  smp;
		pick_t    given;

		// Directed rows, run with the reset limits (600000, 1800000, step 100000). Rows whose pick
		// is plain to see carry it typed in; the rest go through the predictor.
		dir_tab = '{
			// All zero right after reset: the aggregate ratio stays zero, so nothing comes out.
			'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
				22'd0, EXP_NONE, 22'd0, 17'd0},
			// One core fully busy: the pick is clamped to the ceiling, peak load reads one.
			'{32'd100, 32'd50, 32'd100, 32'd100, 32'd100, 32'd75, 32'd100, 32'd0,
				32'd100, 32'd50, 22'd1000000, EXP_GIVEN, 22'd1800000, 17'd65536},
			// Counters unchanged: every ratio drops to zero and the floor is picked.
			'{32'd100, 32'd50, 32'd100, 32'd100, 32'd100, 32'd75, 32'd100, 32'd0,
				32'd100, 32'd50, 22'd1000000, EXP_GIVEN, 22'd600000, 17'd0},
			// Unchanged once more: the aggregate ratio stays zero, no pick.
			'{32'd100, 32'd50, 32'd100, 32'd100, 32'd100, 32'd75, 32'd100, 32'd0,
				32'd100, 32'd50, 22'd1000000, EXP_NONE, 22'd0, 17'd0},
			// Idle above total on the aggregate and on core 0.
			'{32'd200, 32'd300, 32'd200, 32'd300, 32'd200, 32'd150, 32'd200, 32'd100,
				32'd200, 32'd100, 22'd1000000, EXP_PREDICTED, 22'd0, 17'd0},
			// Half load: the pick moves up by whole steps from the present frequency.
			'{32'd300, 32'd250, 32'd300, 32'd280, 32'd300, 32'd200, 32'd300, 32'd200,
				32'd300, 32'd170, 22'd1000000, EXP_PREDICTED, 22'd0, 17'd0},
			// Same aggregate ratio in other terms (100/200 against 50/100): no pick.
			'{32'd500, 32'd350, 32'd500, 32'd400, 32'd500, 32'd300, 32'd500, 32'd350,
				32'd500, 32'd320, 22'd1500000, EXP_PREDICTED, 22'd0, 17'd0},
			// Present frequency at its top: a long way down in steps.
			'{32'd600, 32'd420, 32'd600, 32'd500, 32'd600, 32'd360, 32'd600, 32'd450,
				32'd600, 32'd400, 22'h3FFFFF, EXP_PREDICTED, 22'd0, 17'd0},
			// All counters go backward, as after a wrap.
			'{32'd10, 32'd0, 32'd10, 32'd0, 32'd10, 32'd0, 32'd10, 32'd0,
				32'd10, 32'd0, 22'd0, EXP_PREDICTED, 22'd0, 17'd0},
			// Totals at their top with no idle ticks.
			'{32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0,
				32'hFFFFFFFF, 32'd0, 22'd1234567, EXP_PREDICTED, 22'd0, 17'd0},
			// Idle jumps to the top as well: busy falls, ratios clamp to zero.
			'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
				32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
				22'd0, EXP_PREDICTED, 22'd0, 17'd0},
			// Wrap back to small values.
			'{32'd100, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100,
				32'd100, 32'd100, 22'h3FFFFF, EXP_PREDICTED, 22'd0, 17'd0},
			// Idle runs backward: busy grows faster than total, ratios above one.
			'{32'd200, 32'd50, 32'd200, 32'd20, 32'd200, 32'd150, 32'd200, 32'd100,
				32'd200, 32'd60, 22'd700000, EXP_PREDICTED, 22'd0, 17'd0},
			// Half load from a present frequency of zero.
			'{32'd400, 32'd150, 32'd400, 32'd170, 32'd400, 32'd250, 32'd400, 32'd220,
				32'd400, 32'd200, 22'd0, EXP_PREDICTED, 22'd0, 17'd0},
			// Desired frequency equal to the present one: no step at all.
			'{32'd500, 32'd210, 32'd500, 32'd220, 32'd500, 32'd290, 32'd500, 32'd300,
				32'd500, 32'd270, 22'd1350000, EXP_PREDICTED, 22'd0, 17'd0},
			// Alternating bit patterns on every field, then their complements.
			'{32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'h2AAAAAAA, 32'hCCCCCCCC,
				32'h33333333, 32'hF0F0F0F0, 32'h0F0F0F0F, 32'hFF00FF00, 32'h00FF00FF,
				22'h2AAAAA, EXP_PREDICTED, 22'd0, 17'd0},
			'{32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'h33333333,
				32'hCCCCCCCC, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h00FF00FF, 32'hFF00FF00,
				22'h155555, EXP_PREDICTED, 22'd0, 17'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		for (int i = 0; i < DIR_ROWS; i++) begin
			row        = dir_tab[i];
			smp.tot[0] = row.agg_tot;
			smp.idl[0] = row.agg_idl;
			smp.tot[1] = row.c0_tot;
			smp.idl[1] = row.c0_idl;
			smp.tot[2] = row.c1_tot;
			smp.idl[2] = row.c1_idl;
			smp.tot[3] = row.c2_tot;
			smp.idl[3] = row.c2_idl;
			smp.tot[4] = row.c3_tot;
			smp.idl[4] = row.c3_idl;
			smp.khz    = row.khz;
			given.khz  = row.want_khz;
			given.util = row.want_util;
			feed_sample(smp, row.kind, given);
		end
		// Reset limits; halfway through, the sender holds off until every pick is back.
		run_random(110, 1'b1);

		// Widest window with the finest step, and no gaps on either side for the whole phase.
		settle_idle();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		load_limits(22'd1, FREQ_SAT, 22'd1, 1'b0);
		run_random(110, 1'b0);

		// Floor above ceiling: the ceiling test wins whenever both apply.
		settle_idle();
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		load_limits(FREQ_SAT, 22'd1, FREQ_SAT, 1'b0);
		run_random(90, 1'b0);

		// A zero step counts as one kHz; the spare register index is written and must not matter.
		settle_idle();
		load_limits(22'd800000, 22'd2000000, 22'd0, 1'b1);
		run_random(110, 1'b0);

		// Huge step under a top ceiling: stepping up overshoots and saturates.
		settle_idle();
		load_limits(22'd300000, FREQ_SAT, FREQ_SAT, 1'b0);
		run_random(110, 1'b0);

		for (int i = 0; i < 2; i++) begin
			settle_idle();
			load_limits(FREQ_W'($urandom_range(1, FREQ_SAT)), FREQ_W'($urandom_range(1, FREQ_SAT)),
				FREQ_W'($urandom_range(1, FREQ_SAT)), 1'b0);
			run_random(60, 1'b0);
		end

		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d samples (%0d directed) and %0d frequency picks over %0d limit sets,",
			samples_sent, DIR_ROWS, picks_checked, settings_used);
		$display("with clamps, zero and huge steps, counter wraps, idle gaps and back-pressure.");
		if (mismatches == 0) begin
			$display("utilization_dvfs_governor_core verification clean");
		end else begin
			$display("utilization_dvfs_governor_core verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/udg_pkg.sv
sv/utilization_dvfs_governor_core.sv
tb/tb.sv
